// ===== hdl/kssbd_pkg.sv =====
// kssbd_pkg: constants, register indexes and accumulator type of the keyed
// supersample box downscaler; no dependencies
package kssbd_pkg;

    // supersample factor is a power of two, given by its log2
    localparam int SS_LOG2   = 2;
    localparam int SS        = 1 << SS_LOG2;
    localparam int MAX_SIZE  = 256;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_CFG_W = 9;
    localparam int RGB_W      = 24;
    localparam int ARGB_W     = 32;

    // canvas coordinate, output column and size widths
    localparam int COL_W   = $clog2(MAX_SIZE * SS);
    localparam int OX_W    = $clog2(MAX_SIZE);
    localparam int ESZ_W   = $clog2(MAX_SIZE + 1);
    localparam int CMP_W   = (ESZ_W > SIZE_CFG_W) ? ESZ_W : SIZE_CFG_W;
    localparam int BIG_W   = CMP_W + SS_LOG2;

    // one channel sum over an SS x SS block of 8-bit values
    localparam int SUM_W   = 8 + 2 * SS_LOG2;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR = CFG_IDX_W'(1);

    localparam logic [SIZE_CFG_W-1:0] OUT_SIZE_RST  = SIZE_CFG_W'(32);
    localparam logic [RGB_W-1:0]      KEY_COLOR_RST = 24'hFF00FF;
    localparam logic [7:0]            OPAQUE        = 8'hFF;

    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_acc;

endpackage

// ===== hdl/keyed_supersample_box_downscaler.sv =====
// keyed_supersample_box_downscaler: box-filter downscale of a supersampled
// canvas with color key to premultiplied argb; depends on kssbd_pkg
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  sample in | i_in_valid, o_in_ready, i_sample_rgb      | input
//  pixel out | o_out_valid, i_out_ready, o_argb,         | output
//            | o_last_of_image                           |
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data           | input
//
//  one sample word per clock sustained while the pixel side does not stall;
//  from sample accept to output register, the accumulator memory is read at
//  accept, then the add stage adds and writes
//  accumulator memory is read-before-write with a registered read; the sum
//  in flight is forwarded to a following sample of the same column
//  synchronous active-low reset clears positions and valid flags, resets config;
//  accumulator contents need no clearing, each block's first sample writes
//  a stall on the pixel side holds the add stage only when it must emit
module keyed_supersample_box_downscaler
    import kssbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // sample words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [RGB_W-1:0]      i_sample_rgb,
    // pixel words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ARGB_W-1:0]     o_argb,
    output logic                  o_last_of_image
);

    // configuration registers
    logic [SIZE_CFG_W-1:0] r_out_size;
    logic [RGB_W-1:0]      r_key_color;

    // canvas position of the next sample
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [COL_W-1:0] n_row;

    // accumulate stage
    logic             r_s1_valid;
    logic [OX_W-1:0]  r_s1_ox;
    logic             r_s1_first;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_opaque;
    logic [RGB_W-1:0] r_s1_rgb;
    logic             r_s1_fwd;
    t_acc             r_fwd_data;
    t_acc             r_rd_data;

    // output register
    logic              r_out_valid;
    logic [ARGB_W-1:0] r_argb;
    logic              r_last;

    // accumulator line
    t_acc r_mem [MAX_SIZE];

    logic [CMP_W-1:0] size_raw;
    logic [CMP_W-1:0] size_eff;
    logic [BIG_W-1:0] big;
    logic [COL_W-1:0] big_m1;

    logic             in_acc;
    logic [OX_W-1:0]  in_ox;
    logic             in_first;
    logic             in_emit;
    logic             in_last;
    logic             in_opaque;
    logic             col_end;

    logic             s1_adv;
    logic             s1_wr;
    t_acc             s1_base;
    t_acc             s1_sum;
    logic [7:0]       s1_alpha_in;

    // effective size, clamped to 1..MAX_SIZE
    assign size_raw = CMP_W'(r_out_size);
    always_comb begin
        size_eff = size_raw;
        if (size_raw == '0) begin
            size_eff = CMP_W'(1);
        end else if (size_raw > CMP_W'(MAX_SIZE)) begin
            size_eff = CMP_W'(MAX_SIZE);
        end
    end
    assign big    = {size_eff, {SS_LOG2{1'b0}}};
    assign big_m1 = COL_W'(big - BIG_W'(1));

    // the add stage moves on unless it must emit into a full output register
    assign s1_adv     = !r_s1_emit || !r_out_valid || i_out_ready;
    assign s1_wr      = r_s1_valid && s1_adv;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // decode of the incoming sample position
    assign in_ox     = OX_W'(r_col >> SS_LOG2);
    assign in_first  = (r_col[SS_LOG2-1:0] == '0) && (r_row[SS_LOG2-1:0] == '0);
    assign in_emit   = (r_col[SS_LOG2-1:0] == '1) && (r_row[SS_LOG2-1:0] == '1);
    assign col_end   = (r_col == big_m1);
    assign in_last   = col_end && (r_row == big_m1);
    assign in_opaque = (i_sample_rgb != r_key_color);

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = (r_row == big_m1) ? '0 : (r_row + COL_W'(1));
        end
    end

    // read-modify-write of the column accumulator
    always_comb begin
        if (r_s1_first) begin
            s1_base = '0;
        end else if (r_s1_fwd) begin
            s1_base = r_fwd_data;
        end else begin
            s1_base = r_rd_data;
        end
        s1_alpha_in = r_s1_opaque ? OPAQUE : 8'h00;
        s1_sum.a = s1_base.a + SUM_W'(s1_alpha_in);
        s1_sum.r = s1_base.r + SUM_W'(r_s1_opaque ? r_s1_rgb[23:16] : 8'h00);
        s1_sum.g = s1_base.g + SUM_W'(r_s1_opaque ? r_s1_rgb[15:8]  : 8'h00);
        s1_sum.b = s1_base.b + SUM_W'(r_s1_opaque ? r_s1_rgb[7:0]   : 8'h00);
    end

    // memory port: registered read at accept, write from the add stage
    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_mem[r_s1_ox] <= s1_sum;
        end
        if (in_acc) begin
            r_rd_data  <= r_mem[in_ox];
            r_fwd_data <= s1_sum;
        end
    end

    // control and stage payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size  <= OUT_SIZE_RST;
            r_key_color <= KEY_COLOR_RST;
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_wr && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // a size write restarts the image
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OUT_SIZE: begin
                        r_out_size <= i_cfg_data[SIZE_CFG_W-1:0];
                        r_col      <= '0;
                        r_row      <= '0;
                    end
                    CFG_KEY_COLOR: begin
                        r_key_color <= i_cfg_data[RGB_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ox     <= in_ox;
            r_s1_first  <= in_first;
            r_s1_emit   <= in_emit;
            r_s1_last   <= in_last;
            r_s1_opaque <= in_opaque;
            r_s1_rgb    <= i_sample_rgb;
            // sum being written this edge is not yet visible to the read
            r_s1_fwd    <= s1_wr && (r_s1_ox == in_ox);
        end
        if (s1_wr && r_s1_emit) begin
            // divide by SS*SS by dropping the low bits
            r_argb <= {s1_sum.a[SUM_W-1 -: 8], s1_sum.r[SUM_W-1 -: 8],
                       s1_sum.g[SUM_W-1 -: 8], s1_sum.b[SUM_W-1 -: 8]};
            r_last <= r_s1_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_argb          = r_argb;
    assign o_last_of_image = r_last;

endmodule
